// ----- rtl/mlfq_three_level_scheduler_core_macros.svh -----
// Assertion shorthands for the scheduler core.
// Both sample on the rising edge of clock and are disabled while reset is high.
`ifndef MLFQ_THREE_LEVEL_SCHEDULER_CORE_MACROS_SVH
`define MLFQ_THREE_LEVEL_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication.
`define MLFQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mlfq core: same-cycle check failed");

// Next-cycle implication.
`define MLFQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mlfq core: next-cycle check failed");

`endif

// ----- rtl/mlfq_pkg.sv -----
`default_nettype none

package mlfq_pkg;

   localparam int MaxSlots   = 16;
   localparam int IdxW       = $clog2(MaxSlots);
   localparam int SlotFieldW = 4;
   localparam int TimeW      = 24;
   localparam int WorkW      = 16;
   localparam int QuantW     = 8;
   localparam int CountW     = 5;
   localparam int LevelW     = 2;
   localparam int QueueDepth = 2;
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 8;

   localparam logic [TimeW-1:0]  TimeMax  = {TimeW{1'b1}};
   localparam logic [QuantW-1:0] QuantMax = {QuantW{1'b1}};
   localparam logic [CountW-1:0] DoneMax  = {CountW{1'b1}};

   localparam logic [LevelW-1:0] LEVEL_NONE  = 2'd0;
   localparam logic [LevelW-1:0] LEVEL_ONE   = 2'd1;
   localparam logic [LevelW-1:0] LEVEL_TWO   = 2'd2;
   localparam logic [LevelW-1:0] LEVEL_THREE = 2'd3;

   localparam logic [CsrIdxW-1:0] CSR_PROCESS_COUNT  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_FIRST_QUANTUM  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_SECOND_QUANTUM = 2'd2;

   localparam logic [CountW-1:0] ResetProcessCount  = 5'd0;
   localparam logic [QuantW-1:0] ResetFirstQuantum  = 8'd4;
   localparam logic [QuantW-1:0] ResetSecondQuantum = 8'd8;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      op_type                op;
      logic                  slot_ok;
      logic [SlotFieldW-1:0] slot;
      logic [WorkW-1:0]      arrival;
      logic [WorkW-1:0]      burst;
   } req_item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [CountW-1:0] process_count;
      logic [QuantW-1:0] first_quantum;
      logic [QuantW-1:0] second_quantum;
   } cfg_type;

   typedef struct packed {
      logic [CountW-1:0] done_count;
      logic [TimeW-1:0]  now;
   } back_status_type;

endpackage

`default_nettype wire

// ----- rtl/mlfq_front.sv -----
`default_nettype none

module mlfq_front (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_command,
   input  wire [mlfq_pkg::SlotFieldW-1:0] req_slot,
   input  wire [mlfq_pkg::WorkW-1:0]     req_arrival,
   input  wire [mlfq_pkg::WorkW-1:0]     req_burst,
   input  mlfq_pkg::queue_status_type    q_status,
   output logic                          q_push,
   output mlfq_pkg::req_item_type        q_item
);
   import mlfq_pkg::*;

   logic         item_valid_ff, item_valid_in;
   req_item_type item_ff, item_in;
   logic         accept;

   assign q_push    = item_valid_ff && !q_status.full;
   assign req_stall = item_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign q_item    = item_ff;

   // Classify: decode the command and flag loads aimed beyond the table.
   always_comb begin
      item_in         = item_ff;
      item_valid_in   = item_valid_ff;
      if (q_push) begin
         item_valid_in = 1'b0;
      end
      if (accept) begin
         item_valid_in   = 1'b1;
         item_in.op      = req_command ? OP_TICK : OP_LOAD;
         item_in.slot_ok = (32'(req_slot) < MaxSlots);
         item_in.slot    = req_slot;
         item_in.arrival = req_arrival;
         item_in.burst   = req_burst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ----- rtl/mlfq_queue.sv -----
`default_nettype none

module mlfq_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  mlfq_pkg::req_item_type     push_item,
   input  wire                        pop,
   output mlfq_pkg::req_item_type     pop_item,
   output mlfq_pkg::queue_status_type status
);
   import mlfq_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   req_item_type    entry_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign status.full      = (count_ff == CntW'(QueueDepth));
   assign status.not_empty = (count_ff != '0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign pop_item         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mlfq_back.sv -----
`default_nettype none

module mlfq_back (
   input  wire                             clock,
   input  wire                             reset,
   input  mlfq_pkg::cfg_type               cfg,
   input  mlfq_pkg::queue_status_type      q_status,
   input  mlfq_pkg::req_item_type          q_item,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic                            rsp_ran,
   output logic [mlfq_pkg::SlotFieldW-1:0] rsp_run_slot,
   output logic [mlfq_pkg::LevelW-1:0]     rsp_run_level,
   output logic                            rsp_finished,
   output logic [mlfq_pkg::TimeW-1:0]      rsp_finish_time,
   output logic [mlfq_pkg::TimeW-1:0]      rsp_turnaround,
   output logic [mlfq_pkg::TimeW-1:0]      rsp_waiting,
   output logic                            rsp_all_done,
   output mlfq_pkg::back_status_type       status
);
   import mlfq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   // Process tables
   logic [WorkW-1:0]  arrival_ff [MaxSlots];
   logic [WorkW-1:0]  burst_ff   [MaxSlots];
   logic [WorkW-1:0]  remain_ff  [MaxSlots];
   logic [LevelW-1:0] level_ff   [MaxSlots];

   state_type         state_ff, state_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic              found_ff, found_in;
   logic [IdxW-1:0]   best_idx_ff, best_idx_in;
   logic [LevelW-1:0] best_lvl_ff, best_lvl_in;
   logic [WorkW-1:0]  best_arr_ff, best_arr_in;
   logic [TimeW-1:0]  now_ff, now_in;
   logic [QuantW-1:0] qtimer_ff, qtimer_in;
   logic              last_valid_ff, last_valid_in;
   logic [IdxW-1:0]   last_run_ff, last_run_in;
   logic [CountW-1:0] done_ff, done_in;

   logic                  res_ran_ff, res_ran_in;
   logic [SlotFieldW-1:0] res_slot_ff, res_slot_in;
   logic [LevelW-1:0]     res_level_ff, res_level_in;
   logic                  res_finished_ff, res_finished_in;
   logic [TimeW-1:0]      res_completion_ff, res_completion_in;
   logic [TimeW-1:0]      res_tat_ff, res_tat_in;
   logic [WorkW-1:0]      res_burst_ff, res_burst_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ran_ff, rsp_ran_in;
   logic [SlotFieldW-1:0] rsp_slot_ff, rsp_slot_in;
   logic [LevelW-1:0]     rsp_level_ff, rsp_level_in;
   logic                  rsp_finished_ff, rsp_finished_in;
   logic [TimeW-1:0]      rsp_completion_ff, rsp_completion_in;
   logic [TimeW-1:0]      rsp_tat_ff, rsp_tat_in;
   logic [TimeW-1:0]      rsp_wait_ff, rsp_wait_in;
   logic                  rsp_all_done_ff, rsp_all_done_in;

   logic [WorkW-1:0]  rd_arr, rd_burst, rd_rem;
   logic [LevelW-1:0] rd_lvl;
   logic              elig, take, last_hit, out_free;
   logic [QuantW-1:0] qt_base, qt_inc;
   logic [TimeW-1:0]  now_inc, tat_calc, wait_calc;
   logic [WorkW-1:0]  rem_new;
   logic              load_we, commit_we, demote_we;
   logic [LevelW-1:0] level_wr;
   logic [IdxW-1:0]   load_idx;

   // One read port on every table, addressed by the scan index.
   assign rd_arr   = arrival_ff[idx_ff];
   assign rd_burst = burst_ff[idx_ff];
   assign rd_rem   = remain_ff[idx_ff];
   assign rd_lvl   = level_ff[idx_ff];

   assign elig = (rd_lvl != LEVEL_NONE) && (rd_rem != '0) && (TimeW'(rd_arr) <= now_ff);
   assign take = elig && (!found_ff || (rd_lvl < best_lvl_ff) ||
                          ((rd_lvl == LEVEL_THREE) && (best_lvl_ff == LEVEL_THREE) &&
                           (rd_arr < best_arr_ff)));

   assign last_hit  = last_valid_ff && (last_run_ff == idx_ff);
   assign qt_base   = last_hit ? qtimer_ff : '0;
   assign qt_inc    = (qt_base == QuantMax) ? qt_base : qt_base + QuantW'(1);
   assign now_inc   = (now_ff == TimeMax) ? now_ff : now_ff + TimeW'(1);
   assign rem_new   = rd_rem - WorkW'(1);
   assign tat_calc  = now_inc - TimeW'(rd_arr);
   assign wait_calc = (res_tat_ff >= TimeW'(res_burst_ff)) ?
                      res_tat_ff - TimeW'(res_burst_ff) : '0;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_idx  = q_item.slot[IdxW-1:0];

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      found_in          = found_ff;
      best_idx_in       = best_idx_ff;
      best_lvl_in       = best_lvl_ff;
      best_arr_in       = best_arr_ff;
      now_in            = now_ff;
      qtimer_in         = qtimer_ff;
      last_valid_in     = last_valid_ff;
      last_run_in       = last_run_ff;
      done_in           = done_ff;
      res_ran_in        = res_ran_ff;
      res_slot_in       = res_slot_ff;
      res_level_in      = res_level_ff;
      res_finished_in   = res_finished_ff;
      res_completion_in = res_completion_ff;
      res_tat_in        = res_tat_ff;
      res_burst_in      = res_burst_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_ran_in        = rsp_ran_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_level_in      = rsp_level_ff;
      rsp_finished_in   = rsp_finished_ff;
      rsp_completion_in = rsp_completion_ff;
      rsp_tat_in        = rsp_tat_ff;
      rsp_wait_in       = rsp_wait_ff;
      rsp_all_done_in   = rsp_all_done_ff;
      q_pop             = 1'b0;
      load_we           = 1'b0;
      commit_we         = 1'b0;
      demote_we         = 1'b0;
      level_wr          = best_lvl_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               q_pop = 1'b1;
               if (q_item.op == OP_LOAD) begin
                  load_we = q_item.slot_ok;
                  if (q_item.slot_ok && last_valid_ff && (last_run_ff == load_idx)) begin
                     last_valid_in = 1'b0;
                  end
                  res_ran_in        = 1'b0;
                  res_slot_in       = '0;
                  res_level_in      = LEVEL_NONE;
                  res_finished_in   = 1'b0;
                  res_completion_in = '0;
                  res_tat_in        = '0;
                  res_burst_in      = '0;
                  state_in          = ST_FINISH;
               end else begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               found_in    = 1'b1;
               best_idx_in = idx_ff;
               best_lvl_in = rd_lvl;
               best_arr_in = rd_arr;
            end
            if (idx_ff == IdxW'(MaxSlots - 1)) begin
               idx_in   = take ? idx_ff : best_idx_ff;
               state_in = ST_COMMIT;
            end else begin
               idx_in = idx_ff + IdxW'(1);
            end
         end
         ST_COMMIT: begin
            now_in            = now_inc;
            res_ran_in        = 1'b0;
            res_slot_in       = '0;
            res_level_in      = LEVEL_NONE;
            res_finished_in   = 1'b0;
            res_completion_in = '0;
            res_tat_in        = '0;
            res_burst_in      = '0;
            if (found_ff) begin
               commit_we     = 1'b1;
               last_valid_in = 1'b1;
               last_run_in   = idx_ff;
               res_ran_in    = 1'b1;
               res_slot_in   = SlotFieldW'(idx_ff);
               res_level_in  = best_lvl_ff;
               qtimer_in     = qt_inc;
               if (rem_new == '0) begin
                  res_finished_in   = 1'b1;
                  res_completion_in = now_inc;
                  res_tat_in        = tat_calc;
                  res_burst_in      = rd_burst;
                  done_in           = (done_ff == DoneMax) ? done_ff : done_ff + CountW'(1);
                  qtimer_in         = '0;
               end else if ((best_lvl_ff == LEVEL_ONE) && (qt_inc >= cfg.first_quantum)) begin
                  demote_we = 1'b1;
                  level_wr  = LEVEL_TWO;
                  qtimer_in = '0;
               end else if ((best_lvl_ff == LEVEL_TWO) && (qt_inc >= cfg.second_quantum)) begin
                  demote_we = 1'b1;
                  level_wr  = LEVEL_THREE;
                  qtimer_in = '0;
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_ran_in        = res_ran_ff;
               rsp_slot_in       = res_slot_ff;
               rsp_level_in      = res_level_ff;
               rsp_finished_in   = res_finished_ff;
               rsp_completion_in = res_completion_ff;
               rsp_tat_in        = res_tat_ff;
               rsp_wait_in       = wait_calc;
               rsp_all_done_in   = (done_ff >= cfg.process_count);
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         now_ff        <= '0;
         qtimer_ff     <= '0;
         last_valid_ff <= 1'b0;
         last_run_ff   <= '0;
         done_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         found_ff      <= found_in;
         now_ff        <= now_in;
         qtimer_ff     <= qtimer_in;
         last_valid_ff <= last_valid_in;
         last_run_ff   <= last_run_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      best_idx_ff       <= best_idx_in;
      best_lvl_ff       <= best_lvl_in;
      best_arr_ff       <= best_arr_in;
      res_ran_ff        <= res_ran_in;
      res_slot_ff       <= res_slot_in;
      res_level_ff      <= res_level_in;
      res_finished_ff   <= res_finished_in;
      res_completion_ff <= res_completion_in;
      res_tat_ff        <= res_tat_in;
      res_burst_ff      <= res_burst_in;
      rsp_ran_ff        <= rsp_ran_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_level_ff      <= rsp_level_in;
      rsp_finished_ff   <= rsp_finished_in;
      rsp_completion_ff <= rsp_completion_in;
      rsp_tat_ff        <= rsp_tat_in;
      rsp_wait_ff       <= rsp_wait_in;
      rsp_all_done_ff   <= rsp_all_done_in;
   end

   // Remaining work and level clear on reset; a cleared level marks a slot unloaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxSlots; i++) begin
            remain_ff[i] <= '0;
            level_ff[i]  <= LEVEL_NONE;
         end
      end else begin
         if (load_we) begin
            remain_ff[load_idx] <= q_item.burst;
            level_ff[load_idx]  <= LEVEL_ONE;
         end
         if (commit_we) begin
            remain_ff[idx_ff] <= rem_new;
         end
         if (demote_we) begin
            level_ff[idx_ff] <= level_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         arrival_ff[load_idx] <= q_item.arrival;
         burst_ff[load_idx]   <= q_item.burst;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ran           = rsp_ran_ff;
   assign rsp_run_slot      = rsp_slot_ff;
   assign rsp_run_level     = rsp_level_ff;
   assign rsp_finished      = rsp_finished_ff;
   assign rsp_finish_time   = rsp_completion_ff;
   assign rsp_turnaround    = rsp_tat_ff;
   assign rsp_waiting       = rsp_wait_ff;
   assign rsp_all_done      = rsp_all_done_ff;
   assign status.done_count = done_ff;
   assign status.now        = now_ff;

endmodule

`default_nettype wire

// ----- rtl/mlfq_three_level_scheduler_core.sv -----
// Flow: the front end registers an accepted request and queues it; the engine pops it and
//   applies a load to the tables or, for a tick, scans the 16-slot table one slot per cycle
//   before it commits; each result then goes through the result register to the output.
// The engine takes the next request only once the last result is in the output register.
// Reset: synchronous, active high; clears time, quantum timer, completed count, levels
//   and remaining work, and restores the registers; arrival and burst tables keep contents.
`default_nettype none

`include "mlfq_three_level_scheduler_core_macros.svh"

module mlfq_three_level_scheduler_core (
   input  wire                             clock,
   input  wire                             reset,
   // request channel
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire                             req_command,
   input  wire [mlfq_pkg::SlotFieldW-1:0]  req_slot,
   input  wire [mlfq_pkg::WorkW-1:0]       req_arrival,
   input  wire [mlfq_pkg::WorkW-1:0]       req_burst,
   // result channel
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic                            rsp_ran,
   output logic [mlfq_pkg::SlotFieldW-1:0] rsp_run_slot,
   output logic [mlfq_pkg::LevelW-1:0]     rsp_run_level,
   output logic                            rsp_finished,
   output logic [mlfq_pkg::TimeW-1:0]      rsp_finish_time,
   output logic [mlfq_pkg::TimeW-1:0]      rsp_turnaround,
   output logic [mlfq_pkg::TimeW-1:0]      rsp_waiting,
   output logic                            rsp_all_done,
   // register write port
   input  wire                             csr_write,
   input  wire [mlfq_pkg::CsrIdxW-1:0]     csr_index,
   input  wire [mlfq_pkg::CsrDataW-1:0]    csr_data
);
   import mlfq_pkg::*;

   // Configuration registers. Write them only while the core is quiet; the block does not
   // enforce it, and the engine reads them directly with no shadow copy.
   logic [CountW-1:0] process_count_ff, process_count_in;
   logic [QuantW-1:0] first_quantum_ff, first_quantum_in;
   logic [QuantW-1:0] second_quantum_ff, second_quantum_in;
   cfg_type           cfg;

   // Front end to queue, queue to engine.
   logic             q_push, q_pop;
   req_item_type     push_item, pop_item;
   queue_status_type q_status;
   back_status_type  back_status;

   // Result-side terms for the checks at the end.
   logic             rsp_done_seen;
   logic             rsp_finish_legal;
   logic             rsp_times_ordered;

   // Decode the write; an index with no register behind it is dropped.
   always_comb begin
      process_count_in  = process_count_ff;
      first_quantum_in  = first_quantum_ff;
      second_quantum_in = second_quantum_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PROCESS_COUNT:  process_count_in  = csr_data[CountW-1:0];
            CSR_FIRST_QUANTUM:  first_quantum_in  = csr_data[QuantW-1:0];
            CSR_SECOND_QUANTUM: second_quantum_in = csr_data[QuantW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         process_count_ff  <= ResetProcessCount;
         first_quantum_ff  <= ResetFirstQuantum;
         second_quantum_ff <= ResetSecondQuantum;
      end else begin
         process_count_ff  <= process_count_in;
         first_quantum_ff  <= first_quantum_in;
         second_quantum_ff <= second_quantum_in;
      end
   end

   assign cfg.process_count  = process_count_ff;
   assign cfg.first_quantum  = first_quantum_ff;
   assign cfg.second_quantum = second_quantum_ff;

   // Front end: register each request, decode its command and push it on.
   mlfq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_slot    (req_slot),
      .req_arrival (req_arrival),
      .req_burst   (req_burst),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   // Short queue: lets the front keep taking requests while the engine scans.
   mlfq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // Engine: apply loads, scan and commit ticks, hold the result register.
   mlfq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_status        (q_status),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ran         (rsp_ran),
      .rsp_run_slot    (rsp_run_slot),
      .rsp_run_level   (rsp_run_level),
      .rsp_finished    (rsp_finished),
      .rsp_finish_time (rsp_finish_time),
      .rsp_turnaround  (rsp_turnaround),
      .rsp_waiting     (rsp_waiting),
      .rsp_all_done    (rsp_all_done),
      .status          (back_status)
   );

   assign rsp_done_seen     = rsp_valid && rsp_finished;
   assign rsp_finish_legal  = rsp_ran && (rsp_run_level != LEVEL_NONE);
   assign rsp_times_ordered = (rsp_turnaround <= rsp_finish_time) &&
                              (rsp_waiting <= rsp_turnaround);

   // A finished slot must have run at a real level.
   `MLFQ_ASSERT_NOW(a_finish_has_run, rsp_done_seen, rsp_finish_legal)
   // Turnaround never exceeds completion time, and waiting never exceeds turnaround.
   `MLFQ_ASSERT_NOW(a_time_order, rsp_done_seen, rsp_times_ordered)
   // The completed count only climbs.
   `MLFQ_ASSERT_NEXT(a_done_climbs, 1'b1, back_status.done_count >= $past(back_status.done_count))
   // Time only advances.
   `MLFQ_ASSERT_NEXT(a_time_climbs, 1'b1, back_status.now >= $past(back_status.now))

endmodule

`default_nettype wire
